### hw/rtl/fcct_pkg.sv
// shared types, constants and helpers of the four-channel counter/timer
`default_nettype none
package fcct_pkg;

  localparam int unsigned Channels = 4;
  localparam int unsigned ChainedChannel = 3;
  localparam int unsigned CntW = 18;

  // control word bits
  localparam int unsigned BitControl = 0;
  localparam int unsigned BitReset = 1;
  localparam int unsigned BitConst = 2;
  localparam int unsigned BitTrigger = 3;
  localparam int unsigned BitPrescale = 5;
  localparam int unsigned BitCounter = 6;
  localparam int unsigned BitIrq = 7;

  typedef enum logic [1:0] {
    KIND_WRITE = 2'd0,
    KIND_READ  = 2'd1,
    KIND_TICK  = 2'd2
  } kind_e;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_EXEC  = 7'b0000010,
    S_SUB   = 7'b0000100,
    S_CHK   = 7'b0001000,
    S_PULSE = 7'b0010000,
    S_PCHK  = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_e;

  typedef logic signed [CntW-1:0] cnt_t;

  // reload value: constant (zero means 256), times 16 or 256 in timer mode
  function automatic cnt_t reload(input logic [7:0] ctl, input logic [7:0] tc);
    logic [8:0] t;
    t = (tc == 8'd0) ? 9'd256 : {1'b0, tc};
    if (ctl[BitCounter]) begin
      reload = cnt_t'({9'd0, t});
    end else if (ctl[BitPrescale]) begin
      reload = cnt_t'({1'b0, t, 8'd0});
    end else begin
      reload = cnt_t'({5'd0, t, 4'd0});
    end
  endfunction

endpackage
`default_nettype wire

### hw/rtl/fcct_alu.sv
// shared adder and sign test used by the tick updates of running counters and by timer-mode reads
`default_nettype none
module fcct_alu (
  input  var fcct_pkg::cnt_t a_i,
  input  var fcct_pkg::cnt_t b_i,
  output fcct_pkg::cnt_t     sum_o,
  output logic               le_zero_o
);
  assign sum_o     = a_i + b_i;
  // the operand count is at or below zero: a period end
  assign le_zero_o = a_i[fcct_pkg::CntW-1] || (a_i == '0);
endmodule
`default_nettype wire

### hw/rtl/four_channel_counter_timer_core.sv
// top level of the four-channel counter/timer
`default_nettype none
// Four-channel counter/timer. Each input transaction is a byte write, a byte
// read or a tick of elapsed clocks; each gives exactly one result transaction.
// Tick updates and timer-mode reads run through one shared adder under a small
// sequencer. A write or read passes through an execute and a done state, and
// the input is ready again when its result is shown. A tick visits each
// channel in turn: a running channel that takes part is decremented and
// checked, each period end of a channel reloads it, each period end of channel
// 0 first pulses the chained channel, which is decremented and checked as well
// when it is already running; a short time constant against a large clock
// count therefore means many reloads. The input is not ready while a
// transaction is in work; the result sits in an output register so the next
// input can be taken while it waits, and a finished transaction waits in its
// done state while a held result is not taken.
module four_channel_counter_timer_core #(
  parameter int unsigned CHAINED_CHANNEL = fcct_pkg::ChainedChannel
) (
  input  var logic        clk_i,
  input  var logic        rst_ni,
  input  var logic        s_axis_tvalid_i,
  output logic            s_axis_tready_o,
  // channel [1:0], write_data [9:2], clocks [25:10]
  input  var logic [31:0] s_axis_tdata_i,
  // kind [1:0]
  input  var logic [1:0]  s_axis_tuser_i,
  output logic            m_axis_tvalid_o,
  input  var logic        m_axis_tready_i,
  // read_data [7:0], irq_vector [15:8]
  output logic [15:0]     m_axis_tdata_o,
  // irq_valid [0]
  output logic            m_axis_tuser_o
);
  localparam int unsigned N = fcct_pkg::Channels;
  localparam logic [1:0] Chain = CHAINED_CHANNEL[1:0];

  fcct_pkg::state_e state_q, state_d;
  logic [1:0]  idx_q, idx_d;
  logic [1:0]  kind_q, kind_d;
  logic [1:0]  ch_q, ch_d;
  logic [7:0]  data_q, data_d;
  logic [15:0] clocks_q, clocks_d;
  logic        found_q, found_d;
  logic [7:0]  vec_q, vec_d;
  logic [7:0]  rd_q, rd_d;
  logic        mvalid_q, mvalid_d;
  logic [15:0] mdata_q, mdata_d;
  logic        mirq_q, mirq_d;

  // per-channel state
  logic [N-1:0]   running_q, running_d;
  logic [N-1:0]   await_q, await_d;
  logic [7:0]     ctrl_q [N], ctrl_d [N];
  logic [7:0]     const_q [N], const_d [N];
  logic [7:0]     vecb_q [N], vecb_d [N];
  fcct_pkg::cnt_t cnt_q [N], cnt_d [N];

  // shared unit operands
  logic [1:0]     sel;
  logic [7:0]     ctl;
  fcct_pkg::cnt_t rl;
  fcct_pkg::cnt_t opb;
  fcct_pkg::cnt_t sum;
  logic           le_zero;
  logic [16:0]    amt;
  logic           skip;
  logic           found_v;
  logic [7:0]     own_vec;
  logic [7:0]     chain_vec;
  logic [7:0]     ch0_vec;

  always_comb begin
    if (state_q == fcct_pkg::S_PULSE || state_q == fcct_pkg::S_PCHK) begin
      sel = Chain;
    end else if (state_q == fcct_pkg::S_EXEC) begin
      sel = ch_q;
    end else begin
      sel = idx_q;
    end
  end

  assign ctl = ctrl_q[sel];
  assign rl  = fcct_pkg::reload(ctl, const_q[sel]);
  // counter mode on the middle channels counts half the clocks, rounded up
  assign amt = ctl[fcct_pkg::BitCounter] ? 17'(({1'b0, clocks_q} + 17'd1) >> 1)
                                         : {1'b0, clocks_q};
  assign skip = ctl[fcct_pkg::BitCounter] && (idx_q == 2'd0 || idx_q == 2'd3);

  assign own_vec   = vecb_q[idx_q] + {5'd0, idx_q, 1'b0};
  assign chain_vec = vecb_q[Chain] + {5'd0, Chain, 1'b0};
  assign ch0_vec   = vecb_q[0];

  // operand select for the shared adder
  always_comb begin
    unique case (state_q)
      fcct_pkg::S_EXEC:  opb = ctl[fcct_pkg::BitPrescale] ? fcct_pkg::cnt_t'(255)
                                                          : fcct_pkg::cnt_t'(15);
      fcct_pkg::S_SUB:   opb = -fcct_pkg::cnt_t'(amt);
      fcct_pkg::S_PULSE: opb = -fcct_pkg::cnt_t'(1);
      default:           opb = rl;
    endcase
  end

  fcct_alu u_alu (
    .a_i       (cnt_q[sel]),
    .b_i       (opb),
    .sum_o     (sum),
    .le_zero_o (le_zero)
  );

  always_comb begin
    state_d   = state_q;
    idx_d     = idx_q;
    kind_d    = kind_q;
    ch_d      = ch_q;
    data_d    = data_q;
    clocks_d  = clocks_q;
    found_d   = found_q;
    vec_d     = vec_q;
    rd_d      = rd_q;
    mvalid_d  = mvalid_q;
    mdata_d   = mdata_q;
    mirq_d    = mirq_q;
    running_d = running_q;
    await_d   = await_q;
    ctrl_d    = ctrl_q;
    const_d   = const_q;
    vecb_d    = vecb_q;
    cnt_d     = cnt_q;
    found_v   = found_q;

    if (mvalid_q && m_axis_tready_i) begin
      mvalid_d = 1'b0;
    end

    unique case (state_q)
      fcct_pkg::S_IDLE: begin
        if (s_axis_tvalid_i) begin
          kind_d   = s_axis_tuser_i;
          ch_d     = s_axis_tdata_i[1:0];
          data_d   = s_axis_tdata_i[9:2];
          clocks_d = s_axis_tdata_i[25:10];
          found_d  = 1'b0;
          vec_d    = '0;
          rd_d     = '0;
          state_d  = fcct_pkg::S_EXEC;
        end
      end
      fcct_pkg::S_EXEC: begin
        state_d = fcct_pkg::S_DONE;
        case (kind_q)
          fcct_pkg::KIND_WRITE: begin
            if (await_q[ch_q]) begin
              await_d[ch_q] = 1'b0;
              const_d[ch_q] = data_q;
              if (!running_q[ch_q] &&
                  ((ctl[fcct_pkg::BitConst] && ctl[fcct_pkg::BitReset]) ||
                   (!ctl[fcct_pkg::BitCounter] && !ctl[fcct_pkg::BitTrigger]))) begin
                cnt_d[ch_q]     = fcct_pkg::reload(ctl, data_q);
                running_d[ch_q] = 1'b1;
              end
            end else if (!data_q[fcct_pkg::BitControl]) begin
              vecb_d[ch_q] = data_q;
            end else begin
              ctrl_d[ch_q] = data_q;
              if (data_q[fcct_pkg::BitConst]) await_d[ch_q] = 1'b1;
              if (data_q[fcct_pkg::BitReset]) running_d[ch_q] = 1'b0;
            end
          end
          fcct_pkg::KIND_READ: begin
            if (ctl[fcct_pkg::BitCounter]) begin
              rd_d = cnt_q[ch_q][7:0];
            end else if (ctl[fcct_pkg::BitPrescale]) begin
              rd_d = sum[15:8];
            end else begin
              rd_d = sum[11:4];
            end
          end
          fcct_pkg::KIND_TICK: begin
            idx_d   = '0;
            state_d = fcct_pkg::S_SUB;
          end
          default: ;
        endcase
      end
      fcct_pkg::S_SUB: begin
        if (!skip && running_q[idx_q]) begin
          cnt_d[idx_q] = sum;
          state_d      = fcct_pkg::S_CHK;
        end else if (idx_q == 2'd3) begin
          state_d = fcct_pkg::S_DONE;
        end else begin
          idx_d = idx_q + 2'd1;
        end
      end
      fcct_pkg::S_CHK: begin
        if (le_zero) begin
          // period end: reload; channel 0 first pulses the chained channel
          cnt_d[idx_q] = sum;
          if (idx_q == 2'd0 && Chain != 2'd0) begin
            state_d = fcct_pkg::S_PULSE;
          end else if (ctl[fcct_pkg::BitIrq] && !found_q) begin
            found_d = 1'b1;
            vec_d   = own_vec;
          end
        end else if (idx_q == 2'd3) begin
          state_d = fcct_pkg::S_DONE;
        end else begin
          idx_d   = idx_q + 2'd1;
          state_d = fcct_pkg::S_SUB;
        end
      end
      fcct_pkg::S_PULSE: begin
        if (running_q[Chain]) begin
          cnt_d[Chain] = sum;
          state_d      = fcct_pkg::S_PCHK;
        end else begin
          if (!ctl[fcct_pkg::BitCounter] && ctl[fcct_pkg::BitTrigger]) begin
            cnt_d[Chain]     = rl;
            running_d[Chain] = 1'b1;
          end
          if (ctrl_q[0][fcct_pkg::BitIrq] && !found_q) begin
            found_d = 1'b1;
            vec_d   = ch0_vec;
          end
          state_d = fcct_pkg::S_CHK;
        end
      end
      fcct_pkg::S_PCHK: begin
        if (le_zero) begin
          cnt_d[Chain] = sum;
          if (ctl[fcct_pkg::BitIrq] && !found_v) begin
            found_v = 1'b1;
            vec_d   = chain_vec;
          end
        end
        // channel 0's own interrupt ranks after the chained one
        if (ctrl_q[0][fcct_pkg::BitIrq] && !found_v) begin
          found_v = 1'b1;
          vec_d   = ch0_vec;
        end
        found_d = found_v;
        state_d = fcct_pkg::S_CHK;
        idx_d   = '0;
      end
      fcct_pkg::S_DONE: begin
        if (!mvalid_q || m_axis_tready_i) begin
          mvalid_d = 1'b1;
          mdata_d  = {found_q ? vec_q : 8'd0, rd_q};
          mirq_d   = found_q;
          state_d  = fcct_pkg::S_IDLE;
        end
      end
      default: state_d = fcct_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= fcct_pkg::S_IDLE;
      idx_q     <= '0;
      found_q   <= 1'b0;
      mvalid_q  <= 1'b0;
      running_q <= '0;
      await_q   <= '0;
      for (int i = 0; i < N; i++) begin
        ctrl_q[i]  <= '0;
        const_q[i] <= '0;
        vecb_q[i]  <= '0;
        cnt_q[i]   <= '0;
      end
    end else begin
      state_q   <= state_d;
      idx_q     <= idx_d;
      found_q   <= found_d;
      mvalid_q  <= mvalid_d;
      running_q <= running_d;
      await_q   <= await_d;
      ctrl_q    <= ctrl_d;
      const_q   <= const_d;
      vecb_q    <= vecb_d;
      cnt_q     <= cnt_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    kind_q   <= kind_d;
    ch_q     <= ch_d;
    data_q   <= data_d;
    clocks_q <= clocks_d;
    vec_q    <= vec_d;
    rd_q     <= rd_d;
    mdata_q  <= mdata_d;
    mirq_q   <= mirq_d;
  end

  assign s_axis_tready_o = (state_q == fcct_pkg::S_IDLE);
  assign m_axis_tvalid_o = mvalid_q;
  assign m_axis_tdata_o  = mdata_q;
  assign m_axis_tuser_o  = mirq_q;
endmodule
`default_nettype wire

### hw/rtl/fcct_checker.sv
// port-level checks of the counter/timer, bound to the top level
`default_nettype none
module fcct_checker (
  input var logic        clk_i,
  input var logic        rst_ni,
  input var logic        s_axis_tvalid_i,
  input var logic        s_axis_tready_o,
  input var logic        m_axis_tvalid_o,
  input var logic        m_axis_tready_i,
  input var logic [15:0] m_axis_tdata_o,
  input var logic        m_axis_tuser_o
);
  // one transaction in work at a time
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("input ready right after an accepted transaction");

  // no interrupt means a zero vector
  a_vec_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tuser_o |-> m_axis_tdata_o[15:8] == 8'd0)
    else $error("vector without interrupt");

  // a stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o))
    else $error("stalled result changed");

  // a sampled reset leaves no result offered
  a_reset_quiet: assert property (@(posedge clk_i) !rst_ni |=> !m_axis_tvalid_o)
    else $error("result offered in reset");
endmodule

bind four_channel_counter_timer_core fcct_checker u_fcct_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o)
);
`default_nettype wire
